// ===== rtl/core/awa_pkg.sv =====
// Shared types and constants for the admission window controller.
// Used by awa_step and admission_window_aimd; depends on nothing else.
package awa_pkg;

  localparam int TIME_BITS  = 48;
  localparam int LIMIT_BITS = 16;
  localparam int EPOCH_BITS = 32;
  localparam int GAP_BITS   = 32;
  localparam int COUNT_BITS = 16;
  localparam int FUNC_BITS  = 3;
  localparam int CFG_BITS   = 32;
  localparam int IDX_BITS   = 1;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET  = LIMIT_BITS'(16);
  localparam logic [LIMIT_BITS-1:0] LIMIT_ONE    = LIMIT_BITS'(1);
  localparam logic [GAP_BITS-1:0]   MIN_INTERVAL = GAP_BITS'(1000);
  localparam logic [EPOCH_BITS-1:0] EPOCH_MAX    = '1;
  localparam logic [TIME_BITS-1:0]  TIME_MAX     = '1;

  // Configuration register indexes.
  localparam logic [IDX_BITS-1:0] REG_MAX_LIMIT       = IDX_BITS'(0);
  localparam logic [IDX_BITS-1:0] REG_GROWTH_INTERVAL = IDX_BITS'(1);

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_ADMITTED   = 3'd0,
    FUNC_REJECTED   = 3'd1,
    FUNC_GROW       = 3'd2,
    FUNC_HOLD       = 3'd3,
    FUNC_NEXT_EVENT = 3'd4,
    FUNC_PROGRESS   = 3'd5
  } func_t;

  typedef struct packed {
    logic [LIMIT_BITS-1:0] max_limit;
    logic [GAP_BITS-1:0]   growth_interval;
  } cfg_t;

  typedef struct packed {
    logic [LIMIT_BITS-1:0] limit;
    logic [EPOCH_BITS-1:0] epoch;
    logic [EPOCH_BITS-1:0] decision_epoch;
    logic                  progress_seen;
    logic [TIME_BITS-1:0]  hold_time;
    logic [TIME_BITS-1:0]  next_growth_time;
  } state_t;

  typedef struct packed {
    logic [FUNC_BITS-1:0]  func;
    logic [TIME_BITS-1:0]  now_time;
    logic [COUNT_BITS-1:0] accepted_count;
    logic [EPOCH_BITS-1:0] epoch_tag;
    logic [COUNT_BITS-1:0] inflight;
    logic                  has_work;
    logic [TIME_BITS-1:0]  hold_until;
  } item_t;

  typedef struct packed {
    logic                  changed;
    logic [LIMIT_BITS-1:0] limit_now;
    logic [EPOCH_BITS-1:0] epoch_now;
    logic                  event_valid;
    logic [TIME_BITS-1:0]  event_time;
  } result_t;

  // Window state right after reset or a ceiling write.
  function automatic state_t clear_state(input logic [LIMIT_BITS-1:0] ceiling);
    state_t s;
    s.limit            = ceiling;
    s.epoch            = '0;
    s.decision_epoch   = '0;
    s.progress_seen    = 1'b0;
    s.hold_time        = '0;
    s.next_growth_time = '0;
    return s;
  endfunction

endpackage

// ===== rtl/core/awa_step.sv =====
// Combinational event logic of the admission window controller.
// Takes one registered item, the window state and config; depends on awa_pkg.
module awa_step (
  input  awa_pkg::item_t   item,
  input  awa_pkg::state_t  st,
  input  awa_pkg::cfg_t    cfg,
  output awa_pkg::state_t  st_next,
  output awa_pkg::result_t res
);
  import awa_pkg::*;

  logic [TIME_BITS:0]    timer_sum;
  logic [TIME_BITS-1:0]  timer_after;
  logic [EPOCH_BITS-1:0] epoch_bump;
  logic [LIMIT_BITS-1:0] admit_pick;
  logic [LIMIT_BITS-1:0] reject_pick;
  logic [LIMIT_BITS-1:0] half_limit;
  logic [LIMIT_BITS-1:0] admit_limit;
  logic [LIMIT_BITS-1:0] reject_limit;
  logic                  room_to_grow;
  logic                  grow_ok;

  function automatic logic [LIMIT_BITS-1:0] clamp(input logic [LIMIT_BITS-1:0] v,
                                                  input logic [LIMIT_BITS-1:0] ceil_v);
    logic [LIMIT_BITS-1:0] r;
    r = (v == '0) ? LIMIT_ONE : v;
    if (r > ceil_v) r = ceil_v;
    return r;
  endfunction

  // Retry timer saturates at the largest time value.
  assign timer_sum   = {1'b0, item.now_time} + {{(TIME_BITS-GAP_BITS+1){1'b0}},
                                                cfg.growth_interval};
  assign timer_after = timer_sum[TIME_BITS] ? TIME_MAX : timer_sum[TIME_BITS-1:0];
  assign epoch_bump  = (st.epoch == EPOCH_MAX) ? st.epoch : st.epoch + EPOCH_BITS'(1);

  assign admit_pick   = (item.accepted_count > st.limit) ? item.accepted_count : st.limit;
  assign admit_limit  = clamp(admit_pick, cfg.max_limit);
  assign half_limit   = st.limit >> 1;
  assign reject_pick  = (item.accepted_count > half_limit) ? item.accepted_count : half_limit;
  assign reject_limit = clamp(reject_pick, cfg.max_limit);

  assign room_to_grow = st.progress_seen && (st.limit < cfg.max_limit) && item.has_work;
  assign grow_ok      = room_to_grow && (item.inflight >= st.limit) &&
                        (item.now_time >= st.next_growth_time) &&
                        (item.now_time >= st.hold_time);

  always_comb begin
    st_next         = st;
    res.changed     = 1'b0;
    res.event_valid = 1'b0;
    res.event_time  = '0;
    unique case (func_t'(item.func))
      FUNC_ADMITTED: begin
        st_next.limit = admit_limit;
        res.changed   = (admit_limit != st.limit);
      end
      FUNC_REJECTED: begin
        // A rejection tagged before the last decision is stale and ignored.
        if (item.epoch_tag >= st.decision_epoch) begin
          st_next.limit            = reject_limit;
          st_next.progress_seen    = 1'b0;
          st_next.next_growth_time = timer_after;
          st_next.epoch            = epoch_bump;
          st_next.decision_epoch   = epoch_bump;
          res.changed              = (reject_limit != st.limit);
        end
      end
      FUNC_GROW: begin
        if (grow_ok) begin
          st_next.limit            = st.limit + LIMIT_ONE;
          st_next.epoch            = epoch_bump;
          st_next.progress_seen    = 1'b0;
          st_next.next_growth_time = timer_after;
          res.changed              = 1'b1;
        end
      end
      FUNC_HOLD: begin
        if (item.hold_until > st.hold_time) st_next.hold_time = item.hold_until;
        if (item.hold_until > st.next_growth_time) st_next.next_growth_time = item.hold_until;
      end
      FUNC_NEXT_EVENT: begin
        if (item.now_time < st.hold_time) begin
          res.event_valid = 1'b1;
          res.event_time  = st.hold_time;
        end else if (room_to_grow && (item.now_time < st.next_growth_time)) begin
          res.event_valid = 1'b1;
          res.event_time  = st.next_growth_time;
        end
      end
      FUNC_PROGRESS: begin
        st_next.progress_seen = 1'b1;
      end
      default: begin
      end
    endcase
    res.limit_now = st_next.limit;
    res.epoch_now = st_next.epoch;
  end

endmodule

// ===== rtl/core/admission_window_aimd.sv =====
// Top level of the AIMD admission window controller: input register, window
// state, result register and config registers. Depends on awa_pkg, awa_step.
//
//   Channel   Handshake               Payload
//   in        in_valid / in_ready     func, now_time, accepted_count, epoch_tag,
//                                     inflight, has_work, hold_until
//   out       out_valid / out_ready   changed, limit_now, epoch_now,
//                                     event_valid, event_time
//   cfg       cfg_we (no wait)        cfg_index, cfg_data
//
// An item is captured into the input register on acceptance and evaluated
// against the window state while it sits there; its result is loaded into
// the output register once that register is free or drains. One item per
// cycle is sustained while results are taken. The state update of an item
// happens as its result is loaded, so the next item sees it unless a ceiling
// write in that cycle clears the window. While the output register holds a
// result that is not taken, both registers hold, and in_ready falls once the
// input register also holds an item. Reset is synchronous and restores the
// config defaults (ceiling 16, interval 1000 ms) and a cleared window.
module admission_window_aimd (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [awa_pkg::FUNC_BITS-1:0]    func,
  input  logic [awa_pkg::TIME_BITS-1:0]    now_time,
  input  logic [awa_pkg::COUNT_BITS-1:0]   accepted_count,
  input  logic [awa_pkg::EPOCH_BITS-1:0]   epoch_tag,
  input  logic [awa_pkg::COUNT_BITS-1:0]   inflight,
  input  logic                             has_work,
  input  logic [awa_pkg::TIME_BITS-1:0]    hold_until,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             changed,
  output logic [awa_pkg::LIMIT_BITS-1:0]   limit_now,
  output logic [awa_pkg::EPOCH_BITS-1:0]   epoch_now,
  output logic                             event_valid,
  output logic [awa_pkg::TIME_BITS-1:0]    event_time,
  input  logic                             cfg_we,
  input  logic [awa_pkg::IDX_BITS-1:0]     cfg_index,
  input  logic [awa_pkg::CFG_BITS-1:0]     cfg_data
);
  import awa_pkg::*;

  cfg_t    cfg;
  state_t  st;
  state_t  st_next;
  item_t   item;
  logic    item_valid;
  result_t res;
  logic    advance;
  logic [LIMIT_BITS-1:0] cfg_ceiling;
  logic [GAP_BITS-1:0]   cfg_gap;

  // The item register moves on whenever the output register is free or drains.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !item_valid || advance;

  // A zero ceiling is taken as one; intervals under one second are raised.
  assign cfg_ceiling = (cfg_data[LIMIT_BITS-1:0] == '0) ? LIMIT_ONE
                                                        : cfg_data[LIMIT_BITS-1:0];
  assign cfg_gap     = (cfg_data[GAP_BITS-1:0] < MIN_INTERVAL) ? MIN_INTERVAL
                                                               : cfg_data[GAP_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_limit       <= LIMIT_RESET;
      cfg.growth_interval <= MIN_INTERVAL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_LIMIT:       cfg.max_limit       <= cfg_ceiling;
        REG_GROWTH_INTERVAL: cfg.growth_interval <= cfg_gap;
        default: begin
        end
      endcase
    end
  end

  // Window state. A ceiling write reloads the limit and clears the rest.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= clear_state(LIMIT_RESET);
    end else if (cfg_we && (cfg_index == REG_MAX_LIMIT)) begin
      st <= clear_state(cfg_ceiling);
    end else if (item_valid && advance) begin
      st <= st_next;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.func           <= func;
      item.now_time       <= now_time;
      item.accepted_count <= accepted_count;
      item.epoch_tag      <= epoch_tag;
      item.inflight       <= inflight;
      item.has_work       <= has_work;
      item.hold_until     <= hold_until;
    end
  end

  awa_step u_step (
    .item    (item),
    .st      (st),
    .cfg     (cfg),
    .st_next (st_next),
    .res     (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      changed     <= res.changed;
      limit_now   <= res.limit_now;
      epoch_now   <= res.epoch_now;
      event_valid <= res.event_valid;
      event_time  <= res.event_time;
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the AIMD admission window controller.
// Holds its own model of the window and compares every result against it.
// Depends on awa_pkg and admission_window_aimd.
`timescale 1ns / 100ps

module tb_top;
  import awa_pkg::*;

  // Two func codes have no operation behind them; the block must report
  // its state unchanged for both.
  localparam logic [FUNC_BITS-1:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [FUNC_BITS-1:0] FUNC_SPARE_7 = 3'd7;

  localparam int PHASES = 6;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Every input starts at a known value.
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [FUNC_BITS-1:0]  func           = '0;
  logic [TIME_BITS-1:0]  now_time       = '0;
  logic [COUNT_BITS-1:0] accepted_count = '0;
  logic [EPOCH_BITS-1:0] epoch_tag      = '0;
  logic [COUNT_BITS-1:0] inflight       = '0;
  logic                  has_work       = 1'b0;
  logic [TIME_BITS-1:0]  hold_until     = '0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic                  changed;
  logic [LIMIT_BITS-1:0] limit_now;
  logic [EPOCH_BITS-1:0] epoch_now;
  logic                  event_valid;
  logic [TIME_BITS-1:0]  event_time;
  logic                  cfg_we         = 1'b0;
  logic [IDX_BITS-1:0]   cfg_index      = '0;
  logic [CFG_BITS-1:0]   cfg_data       = '0;

  admission_window_aimd uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .now_time       (now_time),
    .accepted_count (accepted_count),
    .epoch_tag      (epoch_tag),
    .inflight       (inflight),
    .has_work       (has_work),
    .hold_until     (hold_until),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .changed        (changed),
    .limit_now      (limit_now),
    .epoch_now      (epoch_now),
    .event_valid    (event_valid),
    .event_time     (event_time),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Window model. The registers and the window state live here; the driver
  // advances the state once per accepted item, and register writes touch
  // it only while the block is idle.
  // ---------------------------------------------------------------------
  logic [LIMIT_BITS-1:0] cfg_ceiling;
  logic [GAP_BITS-1:0]   cfg_interval;
  logic [LIMIT_BITS-1:0] win_limit;
  logic [EPOCH_BITS-1:0] win_epoch;
  logic [EPOCH_BITS-1:0] win_decision;
  logic                  win_progress;
  logic [TIME_BITS-1:0]  win_hold;
  logic [TIME_BITS-1:0]  win_next_grow;

  int grow_count  = 0;
  int stale_count = 0;
  int wake_count  = 0;

  function automatic void reload_window();
    win_limit     = cfg_ceiling;
    win_epoch     = '0;
    win_decision  = '0;
    win_progress  = 1'b0;
    win_hold      = '0;
    win_next_grow = '0;
  endfunction

  function automatic logic [LIMIT_BITS-1:0] clamp_to_ceiling(input logic [LIMIT_BITS-1:0] v);
    if (v < LIMIT_ONE) return LIMIT_ONE;
    if (v > cfg_ceiling) return cfg_ceiling;
    return v;
  endfunction

  // The growth timer saturates at the largest time instead of wrapping.
  function automatic logic [TIME_BITS-1:0] growth_deadline(input logic [TIME_BITS-1:0] now);
    logic [TIME_BITS:0] sum;
    sum = {1'b0, now} + (TIME_BITS+1)'(cfg_interval);
    return sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
  endfunction

  // Applies one event to the window and returns the result it produces.
  function automatic result_t step_window(input item_t ev);
    result_t               r;
    logic [LIMIT_BITS-1:0] prior;
    logic [LIMIT_BITS-1:0] half;
    r     = '0;
    prior = win_limit;
    unique case (ev.func)
      FUNC_ADMITTED: begin
        win_limit = clamp_to_ceiling((ev.accepted_count > win_limit) ?
                                     ev.accepted_count : win_limit);
        r.changed = (win_limit != prior);
      end
      FUNC_REJECTED: begin
        // A rejection tagged with an epoch older than the last decision
        // belongs to a window that has already been cut.
        if (ev.epoch_tag >= win_decision) begin
          half          = win_limit >> 1;
          win_limit     = clamp_to_ceiling((ev.accepted_count > half) ?
                                           ev.accepted_count : half);
          win_progress  = 1'b0;
          win_next_grow = growth_deadline(ev.now_time);
          win_epoch     = (win_epoch == EPOCH_MAX) ? win_epoch
                                                   : win_epoch + EPOCH_BITS'(1);
          win_decision  = win_epoch;
          r.changed     = (win_limit != prior);
        end else begin
          stale_count++;
        end
      end
      FUNC_GROW: begin
        if (win_progress && win_limit < cfg_ceiling && ev.has_work &&
            ev.inflight >= win_limit && ev.now_time >= win_next_grow &&
            ev.now_time >= win_hold) begin
          win_limit     = win_limit + LIMIT_ONE;
          win_epoch     = (win_epoch == EPOCH_MAX) ? win_epoch
                                                   : win_epoch + EPOCH_BITS'(1);
          win_progress  = 1'b0;
          win_next_grow = growth_deadline(ev.now_time);
          r.changed     = 1'b1;
          grow_count++;
        end
      end
      FUNC_HOLD: begin
        if (ev.hold_until > win_hold) win_hold = ev.hold_until;
        if (ev.hold_until > win_next_grow) win_next_grow = ev.hold_until;
      end
      FUNC_NEXT_EVENT: begin
        // A pending hold wins over a pending growth step.
        if (ev.now_time < win_hold) begin
          r.event_valid = 1'b1;
          r.event_time  = win_hold;
        end else if (ev.has_work && win_progress && win_limit < cfg_ceiling &&
                     ev.now_time < win_next_grow) begin
          r.event_valid = 1'b1;
          r.event_time  = win_next_grow;
        end
        if (r.event_valid) wake_count++;
      end
      FUNC_PROGRESS: begin
        win_progress = 1'b1;
      end
      default: begin
      end
    endcase
    r.limit_now = win_limit;
    r.epoch_now = win_epoch;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Event source. The main sequence fills event_backlog; the driver offers
  // its items one at a time and runs the model on each accepted item.
  // ---------------------------------------------------------------------
  item_t   event_backlog[$];
  result_t due_window_reports[$];
  item_t   offered;
  int      items_taken = 0;

  // While set, neither side inserts random idle cycles; the receiver's long stalls still occur.
  logic steady = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        due_window_reports.push_back(step_window(offered));
        items_taken++;
      end
      // The payload only moves once the current item is gone.
      if (!in_valid || in_ready) begin
        if (event_backlog.size() != 0 && (steady || $urandom_range(99) >= 28)) begin
          offered        = event_backlog.pop_front();
          in_valid       <= 1'b1;
          func           <= offered.func;
          now_time       <= offered.now_time;
          accepted_count <= offered.accepted_count;
          epoch_tag      <= offered.epoch_tag;
          inflight       <= offered.inflight;
          has_work       <= offered.has_work;
          hold_until     <= offered.hold_until;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result side. Each accepted result is compared with the oldest pending
  // report. A few times in the run the receiver stops taking results for a
  // long stretch while the sender keeps going, which fills the block's
  // pipeline and must pull in_ready low.
  // ---------------------------------------------------------------------
  int mismatch_count    = 0;
  int results_seen      = 0;
  int backpressure_left = 0;

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (due_window_reports.size() == 0) begin
          $error("result with no pending report: limit_now 0x%0h", limit_now);
          mismatch_count++;
        end else begin
          want = due_window_reports.pop_front();
          check_field("changed", 64'(want.changed), 64'(changed));
          check_field("limit_now", 64'(want.limit_now), 64'(limit_now));
          check_field("epoch_now", 64'(want.epoch_now), 64'(epoch_now));
          check_field("event_valid", 64'(want.event_valid), 64'(event_valid));
          check_field("event_time", 64'(want.event_time), 64'(event_time));
        end
        if (results_seen % 300 == 150) backpressure_left = 60;
      end
      if (backpressure_left > 0) begin
        backpressure_left--;
        out_ready <= 1'b0;
      end else if (!steady && $urandom_range(99) < 28) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  function automatic logic [TIME_BITS-1:0] rand48();
    return TIME_BITS'({$urandom(), $urandom()});
  endfunction

  function automatic item_t make_item(input logic [FUNC_BITS-1:0] f,
                                      input logic [TIME_BITS-1:0] now,
                                      input logic [COUNT_BITS-1:0] acc,
                                      input logic [EPOCH_BITS-1:0] tag,
                                      input logic [COUNT_BITS-1:0] infl,
                                      input logic work,
                                      input logic [TIME_BITS-1:0] hold_end);
    item_t it;
    it.func           = f;
    it.now_time       = now;
    it.accepted_count = acc;
    it.epoch_tag      = tag;
    it.inflight       = infl;
    it.has_work       = work;
    it.hold_until     = hold_end;
    return it;
  endfunction

  // Generator view of the current phase: a clock that only moves forward,
  // and an upper bound on the epoch so that most rejections carry a fresh
  // tag while some are deliberately stale.
  logic [63:0] gen_clock;
  int unsigned gen_interval;
  int          gen_ceiling;
  int unsigned gen_epoch_bound;

  task automatic queue_random_items(input int count);
    item_t       it;
    int          roll;
    logic [63:0] stride;
    for (int n = 0; n < count; n++) begin
      // One item in five stays pure noise: any code, any field values.
      it = make_item(FUNC_BITS'($urandom_range(7)), rand48(), COUNT_BITS'($urandom()),
                     $urandom(), COUNT_BITS'($urandom()), 1'($urandom()), rand48());
      if ($urandom_range(99) >= 20) begin
        // Time moves in small steps so that the growth timer expires every
        // few items, with an occasional jump of two intervals.
        if ($urandom_range(9) == 0) stride = 64'(gen_interval) * 2;
        else stride = 64'($urandom_range(gen_interval / 3));
        gen_clock += stride;
        if (gen_clock > 64'(TIME_MAX)) gen_clock = 64'(TIME_MAX);
        it.now_time = gen_clock[TIME_BITS-1:0];
        roll = $urandom_range(99);
        if (roll < 10) begin
          it.func           = FUNC_ADMITTED;
          it.accepted_count = COUNT_BITS'($urandom_range(gen_ceiling + 2));
        end else if (roll < 25) begin
          it.func           = FUNC_REJECTED;
          it.accepted_count = COUNT_BITS'($urandom_range(gen_ceiling / 4));
          if ($urandom_range(3) != 0) it.epoch_tag = gen_epoch_bound + $urandom_range(3);
          else it.epoch_tag = $urandom_range(gen_epoch_bound);
          gen_epoch_bound++;
        end else if (roll < 55) begin
          it.func     = FUNC_GROW;
          roll        = $urandom_range(9);
          if (roll < 6) it.inflight = COUNT_BITS'(gen_ceiling);
          else if (roll < 8) it.inflight = COUNT_BITS'($urandom_range(gen_ceiling));
          it.has_work = ($urandom_range(99) < 85);
          gen_epoch_bound++;
        end else if (roll < 63) begin
          it.func = FUNC_HOLD;
          // A far hold would block growth for the rest of the phase.
          if ($urandom_range(49) != 0)
            it.hold_until = TIME_BITS'(gen_clock + $urandom_range(gen_interval));
        end else if (roll < 82) begin
          it.func     = FUNC_NEXT_EVENT;
          it.has_work = ($urandom_range(3) != 0);
        end else begin
          it.func = FUNC_PROGRESS;
        end
      end
      event_backlog.push_back(it);
    end
  endtask

  // Waits until every queued item has been taken and answered.
  task automatic drain_window();
    while (event_backlog.size() != 0 || in_valid || due_window_reports.size() != 0)
      @(posedge clk);
  endtask

  // The model follows a register write at the edge where the block takes it.
  task automatic write_register(input logic [IDX_BITS-1:0] idx,
                                input logic [CFG_BITS-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_LIMIT) begin
      cfg_ceiling = (data[LIMIT_BITS-1:0] == '0) ? LIMIT_ONE : data[LIMIT_BITS-1:0];
      reload_window();
    end else begin
      cfg_interval = (data < MIN_INTERVAL) ? MIN_INTERVAL : data;
    end
  endtask

  // Register settings per phase. A ceiling of zero must read as one, and
  // intervals below one second must read as one second.
  logic [LIMIT_BITS-1:0] ceiling_plan  [PHASES] = '{16'd4, 16'd0, 16'hFFFF, 16'd8,
                                                    16'd3, 16'd32};
  logic [GAP_BITS-1:0]   interval_plan [PHASES] = '{32'd0, 32'd999, 32'hFFFF_FFFF,
                                                    32'd1500, 32'd2500, 32'd1000};
  int                    count_plan    [PHASES] = '{120, 60, 100, 150, 150, 150};

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin
    cfg_ceiling  = LIMIT_RESET;
    cfg_interval = MIN_INTERVAL;
    reload_window();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed walk from the reset state (ceiling 16, one second interval).
    // Nothing is pending yet, so no wake time.
    event_backlog.push_back(make_item(FUNC_NEXT_EVENT, '0, '0, '0, '0, 1'b1, '0));
    event_backlog.push_back(make_item(FUNC_ADMITTED, rand48(), '0, '0, '0, 1'b0, '0));
    // Fresh rejection halves 16 to 8 and arms the timer.
    event_backlog.push_back(make_item(FUNC_REJECTED, 48'd100, '0, '0, '0, 1'b0, '0));
    // Same tag again is now older than the decision epoch: stale.
    event_backlog.push_back(make_item(FUNC_REJECTED, 48'd200, '0, '0, '0, 1'b0, '0));
    // Admitted count above the ceiling clamps back to the ceiling.
    event_backlog.push_back(make_item(FUNC_ADMITTED, '0, 16'hFFFF, '0, '0, 1'b0, '0));
    // Rejection near the end of time: the growth timer saturates.
    event_backlog.push_back(make_item(FUNC_REJECTED, TIME_MAX - 48'd10, 16'd3,
                                      32'hFFFF_FFFF, '0, 1'b0, '0));
    event_backlog.push_back(make_item(FUNC_NEXT_EVENT, 48'd5000, '0, '0, '0, 1'b1, '0));
    event_backlog.push_back(make_item(FUNC_PROGRESS, rand48(), '0, '0, '0, 1'b0, '0));
    event_backlog.push_back(make_item(FUNC_NEXT_EVENT, 48'd5000, '0, '0, '0, 1'b1, '0));
    // Growth exactly at the saturated timer.
    event_backlog.push_back(make_item(FUNC_GROW, TIME_MAX, '0, '0, 16'hFFFF, 1'b1, '0));
    event_backlog.push_back(make_item(FUNC_HOLD, '0, '0, '0, '0, 1'b0, 48'd2000));
    event_backlog.push_back(make_item(FUNC_NEXT_EVENT, 48'd10, '0, '0, '0, 1'b1, '0));
    event_backlog.push_back(make_item(FUNC_REJECTED, '0, '0, 32'd3, '0, 1'b0, '0));
    event_backlog.push_back(make_item(FUNC_PROGRESS, '0, '0, '0, '0, 1'b0, '0));
    // Growth blocked by the hold, then by a short window, then by no work.
    event_backlog.push_back(make_item(FUNC_GROW, 48'd1500, '0, '0, 16'd4, 1'b1, '0));
    event_backlog.push_back(make_item(FUNC_GROW, 48'd2000, '0, '0, 16'd3, 1'b1, '0));
    event_backlog.push_back(make_item(FUNC_GROW, 48'd2000, '0, '0, 16'd4, 1'b0, '0));
    event_backlog.push_back(make_item(FUNC_GROW, 48'd2000, '0, '0, 16'd4, 1'b1, '0));
    // Unused codes, first with every field bit set, then with random fields.
    event_backlog.push_back(make_item(FUNC_SPARE_6, TIME_MAX, 16'hFFFF, 32'hFFFF_FFFF,
                                      16'hFFFF, 1'b1, TIME_MAX));
    event_backlog.push_back(make_item(FUNC_SPARE_7, rand48(), 16'($urandom()), $urandom(),
                                      16'($urandom()), 1'b0, rand48()));
    // Growth without fresh progress is refused.
    event_backlog.push_back(make_item(FUNC_GROW, 48'd9000, '0, '0, 16'hFFFF, 1'b1, '0));
    event_backlog.push_back(make_item(FUNC_HOLD, '0, '0, '0, '0, 1'b0, TIME_MAX));
    event_backlog.push_back(make_item(FUNC_PROGRESS, '0, '0, '0, '0, 1'b0, '0));
    event_backlog.push_back(make_item(FUNC_NEXT_EVENT, TIME_MAX, '0, '0, '0, 1'b1, '0));
    event_backlog.push_back(make_item(FUNC_NEXT_EVENT, '0, '0, '0, '0, 1'b1, '0));
    drain_window();

    // Random phases, each under its own register settings. The ceiling
    // write clears the window, so the generator clock restarts at zero.
    for (int p = 0; p < PHASES; p++) begin
      write_register(REG_GROWTH_INTERVAL, interval_plan[p]);
      write_register(REG_MAX_LIMIT, {16'($urandom()), ceiling_plan[p]});
      gen_ceiling     = int'(cfg_ceiling);
      gen_interval    = cfg_interval;
      gen_clock       = '0;
      gen_epoch_bound = 0;
      steady          = (p == 3);
      queue_random_items(count_plan[p]);
      drain_window();
    end
    steady = 1'b0;

    // Let anything still in the pipeline come out before judging.
    repeat (8) @(posedge clk);
    if (due_window_reports.size() != 0) begin
      $error("%0d results never arrived", due_window_reports.size());
      mismatch_count++;
    end

    $display("Run covered %0d items and %0d results over %0d register settings.",
             items_taken, results_seen, PHASES + 1);
    $display("Window grew %0d times, ignored %0d stale rejections, reported %0d wake times.",
             grow_count, stale_count, wake_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: a correct run finishes in well under a tenth of this.
  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
